@@ hw/rtl/pseudocode_lexer_defines.svh @@
// Assertion helpers for the lexer. Sampled on clk, off while rst_n is low.
`ifndef PSEUDOCODE_LEXER_DEFINES_SVH
`define PSEUDOCODE_LEXER_DEFINES_SVH
`ifndef SYNTHESIS
`define PLX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pseudocode_lexer: same-cycle check failed");
`define PLX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pseudocode_lexer: next-cycle check failed");
`else
`define PLX_ASSERT_IMP(lbl, ante, cons)
`define PLX_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/plx_pkg.sv @@
package plx_pkg;

    // most words one source byte can produce
    localparam int MAX_RES    = 3;
    localparam int RES_CW     = $clog2(MAX_RES + 1);

    // result queue; depth is a power of two, at least MAX_RES
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] tok_char;
        logic       char_valid;
        logic       token_first;
        logic       token_last;
        logic       malformed;
        logic       stream_done;
        logic       run_end;
    } plx_res_t;

    // words produced by one step, lowest index first
    typedef struct packed {
        plx_res_t [MAX_RES-1:0] res;
        logic [RES_CW-1:0]      cnt;
    } plx_push_t;

    typedef struct packed {
        logic [FIFO_CW-1:0] cnt;
        logic               empty;
        logic               room;   // space for a full step
    } plx_fifo_stat_t;

endpackage

@@ hw/rtl/pseudocode_lexer.sv @@
// Pseudocode lexer: one source byte in, zero to three token-byte words out.
// Byte channel: byte_valid/byte_ready carry ch and end_of_input; set
//   end_of_input on the last byte of a source text.
// Result channel: res_valid/res_ready carry one word: tok_char with its
//   token_first/token_last marks, char_valid, run_end on the last word of a
//   byte, and stream_done (with malformed for an unclosed string) on the last
//   word of a text. A byte that yields nothing (a space) sends no word.
// Dataflow: an accepted byte waits in the input register, and its words
//   enter the result queue once it has room; the first is offered as soon as it is in the queue.
// Throughput: one byte per cycle while the queue has room for three words;
//   the result side drains one word per cycle while res_ready is high, so bytes that expand into
//   several words (operators after a word) slow the byte side to match.
// Stall: when res_ready is low the 8-word queue fills, the input register
//   holds its byte and byte_ready drops. Nothing is lost or repeated.
// Reset: queue empty, lexer in normal mode at the start of a line, no byte
//   held. After each end_of_input the lexer returns to that same state.
module pseudocode_lexer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] ch,
    input  logic       end_of_input,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] tok_char,
    output logic       char_valid,
    output logic       token_first,
    output logic       token_last,
    output logic       malformed,
    output logic       stream_done,
    output logic       run_end
);

`include "pseudocode_lexer_defines.svh"

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] ch_reg;
    logic       eoi_reg;

    logic                    advance;
    logic                    pop;
    plx_pkg::plx_push_t      step;
    plx_pkg::plx_push_t      push_q;
    plx_pkg::plx_res_t       head;
    plx_pkg::plx_fifo_stat_t fifo_stat;

    // the held byte is lexed only when the queue can take all its words
    assign advance       = in_valid_reg && fifo_stat.room;
    assign byte_ready    = !in_valid_reg || fifo_stat.room;
    assign in_valid_next = (byte_valid && byte_ready) || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            ch_reg  <= ch;
            eoi_reg <= end_of_input;
        end
    end

    plx_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .ch      (ch_reg),
        .eoi     (eoi_reg),
        .push    (step)
    );

    always_comb
    begin
        push_q = step;
        if (!advance)
            push_q.cnt = '0;
    end

    assign pop = res_valid && res_ready;

    plx_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_q),
        .pop   (pop),
        .head  (head),
        .stat  (fifo_stat)
    );

    assign res_valid   = !fifo_stat.empty;
    assign tok_char    = head.tok_char;
    assign char_valid  = head.char_valid;
    assign token_first = head.token_first;
    assign token_last  = head.token_last;
    assign malformed   = head.malformed;
    assign stream_done = head.stream_done;
    assign run_end     = head.run_end;

    // the final byte of a text always yields the done word
    `PLX_ASSERT_IMP(a_eoi_emits, advance && eoi_reg, step.cnt != '0)
    // queue never overfills
    `PLX_ASSERT_IMP(a_fifo_bound, 1'b1, fifo_stat.cnt <= plx_pkg::FIFO_CW'(plx_pkg::FIFO_DEPTH))
    // queue occupancy follows pushes and pops
    `PLX_ASSERT_NXT(a_fifo_track, 1'b1, fifo_stat.cnt == $past(fifo_stat.cnt) + plx_pkg::FIFO_CW'($past(push_q.cnt)) - plx_pkg::FIFO_CW'($past(pop)))
    // a byte that cannot advance stays in the input register
    `PLX_ASSERT_NXT(a_hold_byte, in_valid_reg && !advance, in_valid_reg && $stable(ch_reg))

endmodule

@@ hw/rtl/plx_fifo.sv @@
module plx_fifo
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  plx_pkg::plx_push_t      push,
    input  logic                    pop,
    output plx_pkg::plx_res_t       head,
    output plx_pkg::plx_fifo_stat_t stat
);

    plx_pkg::plx_res_t mem_reg [plx_pkg::FIFO_DEPTH];

    logic [plx_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [plx_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [plx_pkg::FIFO_CW-1:0] cnt_reg, cnt_next;

    assign wr_ptr_next = wr_ptr_reg + plx_pkg::FIFO_AW'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + plx_pkg::FIFO_AW'(pop);
    assign cnt_next    = cnt_reg + plx_pkg::FIFO_CW'(push.cnt) - plx_pkg::FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // up to MAX_RES entries land in consecutive slots
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < plx_pkg::MAX_RES; i++)
        begin
            if (plx_pkg::RES_CW'(i) < push.cnt)
            begin
                mem_reg[wr_ptr_reg + plx_pkg::FIFO_AW'(i)] <= push.res[i];
            end
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.cnt   = cnt_reg;
    assign stat.empty = (cnt_reg == '0);
    assign stat.room  = (cnt_reg <= plx_pkg::FIFO_CW'(plx_pkg::FIFO_DEPTH - plx_pkg::MAX_RES));

endmodule

@@ hw/rtl/plx_core.sv @@
module plx_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [7:0]         ch,
    input  logic               eoi,
    output plx_pkg::plx_push_t push
);

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [1:0] {M_NORMAL, M_STRING, M_COMMENT, M_BANG} mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] held_byte;
        logic       held_valid;
        logic       word_open;
        logic       at_line_start;
        logic       prev_bs;
    } lex_state_t;

    typedef struct packed {
        lex_state_t         st;
        plx_pkg::plx_push_t o;
    } ctx_t;

    localparam lex_state_t RST_ST = '{
        mode: M_NORMAL, held_byte: 8'h00, held_valid: 1'b0,
        word_open: 1'b0, at_line_start: 1'b1, prev_bs: 1'b0};

    lex_state_t state_reg, state_next;
    ctx_t       x;

    // append a word; words past MAX_RES are dropped
    function automatic ctx_t put(ctx_t c, logic [7:0] b, logic v, logic f, logic l);
        plx_pkg::plx_res_t r;
        r = '0;
        r.char_valid = v;
        if (v)
        begin
            r.tok_char    = b;
            r.token_first = f;
            r.token_last  = l;
        end
        if (c.o.cnt != plx_pkg::RES_CW'(plx_pkg::MAX_RES))
        begin
            c.o.res[c.o.cnt] = r;
            c.o.cnt          = c.o.cnt + plx_pkg::RES_CW'(1);
        end
        return c;
    endfunction

    function automatic logic is_single(logic [7:0] c);
        return c inside {CH_COMMA, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_LBRACE,
                         CH_RBRACE, CH_PLUS, CH_MINUS, CH_STAR, CH_EQ};
    endfunction

    function automatic logic starts_delim(logic [7:0] c);
        return is_single(c) ||
               (c inside {CH_SPACE, CH_TAB, CH_NL, CH_QUOTE, CH_LT, CH_GT, CH_SLASH});
    endfunction

    // nothing held, no word open
    function automatic ctx_t fresh(ctx_t s, logic [7:0] c);
        if (c == CH_SPACE)
        begin
            return s;
        end
        else if (c == CH_TAB)
        begin
            if (s.st.at_line_start)
            begin
                s = put(s, c, 1'b1, 1'b1, 1'b1);
            end
        end
        else if (c == CH_NL)
        begin
            s = put(s, c, 1'b1, 1'b1, 1'b1);
            s.st.at_line_start = 1'b1;
        end
        else if (is_single(c))
        begin
            s = put(s, c, 1'b1, 1'b1, 1'b1);
            s.st.at_line_start = 1'b0;
        end
        else if (c == CH_QUOTE)
        begin
            s = put(s, c, 1'b1, 1'b1, 1'b0);
            s.st.mode    = M_STRING;
            s.st.prev_bs = 1'b0;
        end
        else
        begin
            s.st.held_byte  = c;
            s.st.held_valid = 1'b1;
            s.st.word_open  = 1'b0;
        end
        return s;
    endfunction

    // held byte belongs to a word
    function automatic ctx_t word_next(ctx_t s, logic [7:0] c);
        if (c == CH_BANG)
        begin
            s.st.mode = M_BANG;
        end
        else if (starts_delim(c))
        begin
            s = put(s, s.st.held_byte, 1'b1, !s.st.word_open, 1'b1);
            s.st.word_open  = 1'b0;
            s.st.held_valid = 1'b0;
            s = fresh(s, c);
        end
        else
        begin
            s = put(s, s.st.held_byte, 1'b1, !s.st.word_open, 1'b0);
            s.st.word_open = 1'b1;
            s.st.held_byte = c;
        end
        return s;
    endfunction

    function automatic ctx_t pair(ctx_t s, logic [7:0] a, logic [7:0] b);
        s = put(s, a, 1'b1, 1'b1, 1'b0);
        s = put(s, b, 1'b1, 1'b0, 1'b1);
        s.st.held_valid    = 1'b0;
        s.st.word_open     = 1'b0;
        s.st.at_line_start = 1'b0;
        return s;
    endfunction

    function automatic ctx_t lone(ctx_t s, logic [7:0] a, logic [7:0] c);
        s = put(s, a, 1'b1, 1'b1, 1'b1);
        s.st.held_valid    = 1'b0;
        s.st.at_line_start = 1'b0;
        return fresh(s, c);
    endfunction

    function automatic ctx_t normal_next(ctx_t s, logic [7:0] c);
        logic [7:0] h;
        h = s.st.held_byte;
        if (!s.st.held_valid)
        begin
            s = fresh(s, c);
        end
        else if (h == CH_LT)
        begin
            s = (c == CH_MINUS || c == CH_EQ) ? pair(s, h, c) : lone(s, h, c);
        end
        else if (h == CH_GT)
        begin
            s = (c == CH_EQ) ? pair(s, h, c) : lone(s, h, c);
        end
        else if (h == CH_SLASH)
        begin
            if (c == CH_SLASH)
            begin
                s = put(s, h, 1'b1, 1'b1, 1'b0);
                s.st.held_byte = c;
                s.st.mode      = M_COMMENT;
            end
            else
            begin
                s = lone(s, h, c);
            end
        end
        else if (h == CH_BANG && !s.st.word_open && c == CH_EQ)
        begin
            s = pair(s, h, c);
        end
        else
        begin
            s = word_next(s, c);
        end
        return s;
    endfunction

    function automatic ctx_t bang_next(ctx_t s, logic [7:0] c);
        s.st.mode = M_NORMAL;
        if (c == CH_EQ)
        begin
            s = put(s, s.st.held_byte, 1'b1, !s.st.word_open, 1'b1);
            s = pair(s, CH_BANG, c);
        end
        else
        begin
            s = put(s, s.st.held_byte, 1'b1, !s.st.word_open, 1'b0);
            s.st.word_open  = 1'b1;
            s.st.held_byte  = CH_BANG;
            s.st.held_valid = 1'b1;
            s = word_next(s, c);
        end
        return s;
    endfunction

    // end of text: drain what is held, tag the last word
    function automatic ctx_t flush(ctx_t s);
        logic                bad;
        logic [plx_pkg::RES_CW-1:0] last;
        bad = (s.st.mode == M_STRING);
        case (s.st.mode)
            M_STRING:  ;
            M_COMMENT: s = put(s, s.st.held_byte, 1'b1, 1'b0, 1'b1);
            M_BANG:
            begin
                s = put(s, s.st.held_byte, 1'b1, !s.st.word_open, 1'b0);
                s = put(s, CH_BANG, 1'b1, 1'b0, 1'b1);
            end
            default:
            begin
                if (s.st.held_valid)
                begin
                    if (s.st.held_byte inside {CH_LT, CH_GT, CH_SLASH})
                        s = put(s, s.st.held_byte, 1'b1, 1'b1, 1'b1);
                    else
                        s = put(s, s.st.held_byte, 1'b1, !s.st.word_open, 1'b1);
                end
            end
        endcase
        if (s.o.cnt == '0)
        begin
            s = put(s, 8'h00, 1'b0, 1'b0, 1'b0);
        end
        last = s.o.cnt - plx_pkg::RES_CW'(1);
        s.o.res[last].malformed   = bad;
        s.o.res[last].stream_done = 1'b1;
        return s;
    endfunction

    always_comb
    begin
        x.st = state_reg;
        x.o  = '0;
        case (state_reg.mode)
            M_STRING:
            begin
                x = put(x, ch, 1'b1, 1'b0, (ch == CH_QUOTE) && !state_reg.prev_bs);
                if ((ch == CH_QUOTE) && !state_reg.prev_bs)
                    x.st.mode = M_NORMAL;
                x.st.prev_bs = (ch == CH_BSLASH);
            end
            M_COMMENT:
            begin
                if (ch == CH_NL)
                begin
                    x = put(x, state_reg.held_byte, 1'b1, 1'b0, 1'b1);
                    x.st.held_valid = 1'b0;
                    x.st.mode       = M_NORMAL;
                end
                else
                begin
                    x = put(x, state_reg.held_byte, 1'b1, 1'b0, 1'b0);
                    x.st.held_byte = ch;
                end
            end
            M_BANG:  x = bang_next(x, ch);
            default: x = normal_next(x, ch);
        endcase
        if (eoi)
        begin
            x    = flush(x);
            x.st = RST_ST;
        end
        if (x.o.cnt != '0)
        begin
            x.o.res[x.o.cnt - plx_pkg::RES_CW'(1)].run_end = 1'b1;
        end
    end

    assign push       = x.o;
    assign state_next = step_en ? x.st : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= RST_ST;
        else
            state_reg <= state_next;
    end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // run limits
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;      // words reach the queue through the input register
    localparam int HOLD_CYCLES  = 300;     // long result-side stall, fills the queue
    localparam int RANDOM_BYTES = 85;

    // byte codes the lexer treats specially
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [1:0] {
        LX_NORMAL,
        LX_STRING,
        LX_COMMENT,
        LX_BANG      // word byte held, '!' waiting for its lookahead
    } lex_mode_t;

    typedef logic [7:0] text_t[$];

    // Tracks lexer state per accepted byte and keeps the words still owed.
    class lex_scoreboard_t;
        lex_mode_t          mode;
        logic [7:0]         held;
        bit                 held_v;
        bit                 word_open;
        bit                 line_start;
        bit                 in_escape;
        plx_pkg::plx_res_t  step_words[$];
        plx_pkg::plx_res_t  pending_words[$];
        int unsigned        mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            mode       = LX_NORMAL;
            held       = 8'h00;
            held_v     = 1'b0;
            word_open  = 1'b0;
            line_start = 1'b1;
            in_escape  = 1'b0;
        endfunction

        // one step never yields more than MAX_RES words; extras are dropped
        function void emit(logic [7:0] b, bit first, bit last);
            plx_pkg::plx_res_t w;
            if (step_words.size() >= plx_pkg::MAX_RES)
                return;
            w             = '0;
            w.tok_char    = b;
            w.char_valid  = 1'b1;
            w.token_first = first;
            w.token_last  = last;
            step_words.insert(step_words.size(), w);
        endfunction

        function bit is_single(logic [7:0] c);
            return c inside {CH_COMMA, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
                             CH_LBRACE, CH_RBRACE, CH_PLUS, CH_MINUS, CH_STAR, CH_EQ};
        endfunction

        function bit starts_delim(logic [7:0] c);
            return is_single(c) ||
                   (c inside {CH_SPACE, CH_TAB, CH_NL, CH_QUOTE, CH_LT, CH_GT, CH_SLASH});
        endfunction

        // nothing held, no word open
        function void take_fresh(logic [7:0] c);
            if (c == CH_SPACE)
                return;
            else if (c == CH_TAB)
            begin
                if (line_start)
                    emit(c, 1'b1, 1'b1);
            end
            else if (c == CH_NL)
            begin
                emit(c, 1'b1, 1'b1);
                line_start = 1'b1;
            end
            else if (is_single(c))
            begin
                emit(c, 1'b1, 1'b1);
                line_start = 1'b0;
            end
            else if (c == CH_QUOTE)
            begin
                emit(c, 1'b1, 1'b0);
                mode      = LX_STRING;
                in_escape = 1'b0;
            end
            else
            begin
                held      = c;
                held_v    = 1'b1;
                word_open = 1'b0;
            end
        endfunction

        // held byte is a word byte, c is its lookahead
        function void word_next(logic [7:0] c);
            if (c == CH_BANG)
                mode = LX_BANG;
            else if (starts_delim(c))
            begin
                emit(held, !word_open, 1'b1);
                word_open = 1'b0;
                held_v    = 1'b0;
                take_fresh(c);
            end
            else
            begin
                emit(held, !word_open, 1'b0);
                word_open = 1'b1;
                held      = c;
            end
        endfunction

        function void two_byte_op(logic [7:0] a, logic [7:0] b);
            emit(a, 1'b1, 1'b0);
            emit(b, 1'b0, 1'b1);
            held_v     = 1'b0;
            word_open  = 1'b0;
            line_start = 1'b0;
        endfunction

        function void one_byte_op(logic [7:0] a, logic [7:0] c);
            emit(a, 1'b1, 1'b1);
            held_v     = 1'b0;
            line_start = 1'b0;
            take_fresh(c);
        endfunction

        function void normal_next(logic [7:0] c);
            if (!held_v)
                take_fresh(c);
            else if (held == CH_LT)
            begin
                if (c == CH_MINUS || c == CH_EQ)
                    two_byte_op(held, c);
                else
                    one_byte_op(held, c);
            end
            else if (held == CH_GT)
            begin
                if (c == CH_EQ)
                    two_byte_op(held, c);
                else
                    one_byte_op(held, c);
            end
            else if (held == CH_SLASH)
            begin
                if (c == CH_SLASH)
                begin
                    emit(held, 1'b1, 1'b0);
                    held = c;
                    mode = LX_COMMENT;
                end
                else
                    one_byte_op(held, c);
            end
            else if (held == CH_BANG && !word_open && c == CH_EQ)
                two_byte_op(held, c);
            else
                word_next(c);
        endfunction

        function void bang_next(logic [7:0] c);
            mode = LX_NORMAL;
            if (c == CH_EQ)
            begin
                emit(held, !word_open, 1'b1);
                two_byte_op(CH_BANG, c);
            end
            else
            begin
                // lone '!' is just another word byte
                emit(held, !word_open, 1'b0);
                word_open = 1'b1;
                held      = CH_BANG;
                held_v    = 1'b1;
                word_next(c);
            end
        endfunction

        // end of text: push out whatever is held, tag the last word
        function void flush();
            bit                unclosed;
            plx_pkg::plx_res_t blank;
            unclosed = 1'b0;
            blank    = '0;
            case (mode)
                LX_STRING:  unclosed = 1'b1;
                LX_COMMENT: emit(held, 1'b0, 1'b1);
                LX_BANG:
                begin
                    emit(held, !word_open, 1'b0);
                    emit(CH_BANG, 1'b0, 1'b1);
                end
                default:
                begin
                    if (held_v)
                    begin
                        if (held inside {CH_LT, CH_GT, CH_SLASH})
                            emit(held, 1'b1, 1'b1);
                        else
                            emit(held, !word_open, 1'b1);
                    end
                end
            endcase
            if (step_words.size() == 0)
                step_words.insert(0, blank);
            step_words[step_words.size()-1].malformed   = unclosed;
            step_words[step_words.size()-1].stream_done = 1'b1;
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            bit closes;
            step_words.delete();
            case (mode)
                LX_STRING:
                begin
                    closes = (c == CH_QUOTE) && !in_escape;
                    emit(c, 1'b0, closes);
                    if (closes)
                        mode = LX_NORMAL;
                    in_escape = (c == CH_BSLASH);
                end
                LX_COMMENT:
                begin
                    // the newline closes the comment and is swallowed
                    if (c == CH_NL)
                    begin
                        emit(held, 1'b0, 1'b1);
                        held_v = 1'b0;
                        mode   = LX_NORMAL;
                    end
                    else
                    begin
                        emit(held, 1'b0, 1'b0);
                        held = c;
                    end
                end
                LX_BANG: bang_next(c);
                default: normal_next(c);
            endcase
            if (last)
            begin
                flush();
                clear();
            end
            if (step_words.size() > 0)
                step_words[step_words.size()-1].run_end = 1'b1;
            foreach (step_words[i])
                pending_words.insert(pending_words.size(), step_words[i]);
        endfunction

        function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_word(plx_pkg::plx_res_t got);
            plx_pkg::plx_res_t exp_w;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            exp_w = pending_words.pop_front();
            cmp_field("tok_char",    32'(exp_w.tok_char),    32'(got.tok_char));
            cmp_field("char_valid",  32'(exp_w.char_valid),  32'(got.char_valid));
            cmp_field("token_first", 32'(exp_w.token_first), 32'(got.token_first));
            cmp_field("token_last",  32'(exp_w.token_last),  32'(got.token_last));
            cmp_field("malformed",   32'(exp_w.malformed),   32'(got.malformed));
            cmp_field("stream_done", 32'(exp_w.stream_done), 32'(got.stream_done));
            cmp_field("run_end",     32'(exp_w.run_end),     32'(got.run_end));
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       byte_valid   = 1'b0;
    logic       byte_ready;
    logic [7:0] ch           = 8'h00;
    logic       end_of_input = 1'b0;
    logic       res_valid;
    logic       res_ready    = 1'b0;
    logic [7:0] tok_char;
    logic       char_valid;
    logic       token_first;
    logic       token_last;
    logic       malformed;
    logic       stream_done;
    logic       run_end;

    lex_scoreboard_t sb = new();
    int  burst_left   = 0;
    int  cycle_count  = 0;
    bit  hold_req     = 1'b0;    // main flow asks the result side for one long stall

    string op_list [18] = '{"<-", "<=", "<", ">=", ">", "=", "!=", "+", "-", "*",
                            "/", "(", ")", "[", "]", "{", "}", ","};

    pseudocode_lexer u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .ch           (ch),
        .end_of_input (end_of_input),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .tok_char     (tok_char),
        .char_valid   (char_valid),
        .token_first  (token_first),
        .token_last   (token_last),
        .malformed    (malformed),
        .stream_done  (stream_done),
        .run_end      (run_end)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // hard stop if the run hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic void add_byte(ref text_t t, input logic [7:0] b);
        t.insert(t.size(), b);
    endfunction

    function automatic void add_str(ref text_t t, input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(t, s[i]);
    endfunction

    // Send one source text; end_of_input rides on its last byte.
    // The sender runs in bursts; when a burst runs out it goes idle before the next one.
    task automatic send_text(ref text_t t);
        foreach (t[i])
        begin
            if (burst_left == 0)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
            end
            byte_valid   <= 1'b1;
            ch           <= t[i];
            end_of_input <= (i == t.size() - 1);
            do @(posedge clk); while (!byte_ready);
            sb.note_byte(t[i], i == t.size() - 1);
            burst_left--;
        end
    endtask

    // Result side: check each accepted word, then pick next ready.
    // Style is redrawn at random as cycle_count advances: always ready, mostly ready,
    // ready on a stride of cycle_count, coin flip. One long hold-off when the main flow asks.
    initial
    begin
        int  style;
        int  hold_left;
        bit  hold_done;
        style     = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
                sb.check_word({tok_char, char_valid, token_first, token_last,
                               malformed, stream_done, run_end});
            if (cycle_count % 64 == 0)
                style = $urandom_range(0, 3);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (!rst_n)
                res_ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                case (style)
                    0:       res_ready <= 1'b1;
                    1:       res_ready <= ($urandom_range(0, 3) != 0);
                    2:       res_ready <= (cycle_count % 3 == 0);
                    default: res_ready <= 1'($urandom_range(0, 1));
                endcase
        end
    end

    initial
    begin
        text_t      t;
        int         sent_bytes;
        int         n_pieces;
        int         n_chars;
        logic [7:0] b;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // tab at line start, string with an escaped quote left open at the end
        t = {};
        add_str(t, "\t\"\\\"\n");
        send_text(t);
        // byte values 00/ff as word bytes, != after a word, two-byte ops,
        // lone '!' at the start of a word, lone '<', lone '/' flushed at the end
        t = {};
        add_byte(t, 8'h00);
        add_byte(t, 8'hFF);
        add_str(t, "!=<-<=>=!z<1/");
        send_text(t);
        // comment cut off by end of text
        t = {};
        add_str(t, "k//c");
        send_text(t);
        // text that yields nothing but the done word
        t = {};
        add_str(t, " ");
        send_text(t);

        // --- random texts ---
        hold_req   = 1'b1;
        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            t        = {};
            n_pieces = $urandom_range(2, 12);
            repeat (n_pieces)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        n_chars = $urandom_range(1, 4);
                        repeat (n_chars)
                            add_byte(t, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                    : 8'($urandom_range(97, 122)));
                    end
                    2:  add_str(t, op_list[$urandom_range(0, 17)]);
                    3:  add_byte(t, CH_SPACE);
                    4:  add_byte(t, CH_TAB);
                    5:  add_byte(t, CH_NL);
                    6:
                    begin
                        add_byte(t, CH_QUOTE);
                        n_chars = $urandom_range(0, 5);
                        repeat (n_chars)
                            case ($urandom_range(0, 5))
                                0:
                                begin
                                    add_byte(t, CH_BSLASH);
                                    add_byte(t, CH_QUOTE);
                                end
                                1:  add_byte(t, CH_NL);
                                2:  add_byte(t, CH_BSLASH);
                                3:
                                begin
                                    b = 8'($urandom_range(0, 255));
                                    add_byte(t, (b == CH_QUOTE) ? CH_SPACE : b);
                                end
                                default: add_byte(t, 8'($urandom_range(97, 122)));
                            endcase
                        add_byte(t, CH_QUOTE);
                    end
                    7:
                    begin
                        add_str(t, "//");
                        n_chars = $urandom_range(0, 4);
                        repeat (n_chars)
                        begin
                            b = 8'($urandom_range(0, 255));
                            add_byte(t, (b == CH_NL) ? CH_SPACE : b);
                        end
                        add_byte(t, CH_NL);
                    end
                    8:
                    begin
                        // '!' in and around words
                        add_byte(t, 8'($urandom_range(97, 122)));
                        add_byte(t, CH_BANG);
                        if ($urandom_range(0, 1))
                            add_byte(t, CH_EQ);
                        add_byte(t, 8'($urandom_range(97, 122)));
                    end
                    default: add_byte(t, 8'($urandom_range(0, 255)));
                endcase
            end
            // now and then a text that ends inside a string
            if ($urandom_range(0, 5) == 0)
            begin
                add_byte(t, CH_QUOTE);
                add_byte(t, 8'($urandom_range(97, 122)));
            end
            sent_bytes += t.size();
            send_text(t);
        end
        byte_valid <= 1'b0;

        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/plx_pkg.sv
hw/rtl/plx_fifo.sv
hw/rtl/plx_core.sv
hw/rtl/pseudocode_lexer.sv
sim/tb_top.sv
